// ===== design/rstk_pkg.sv =====
// Package for the retransmit slot tracker: widths, command and result codes,
// table entry and memory request types. No dependencies.

package rstk_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int IDX_W     = $clog2(NUM_SLOTS);

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 5;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 3;
  localparam int TMO_W   = 16;

  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd2;

  localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SENT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK_OK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK_IGN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RETX    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_ACK,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [ID_W-1:0]   ident;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } ram_req_t;

endpackage

// ===== design/rstk_if.sv =====
// Valid/ready channel interfaces for the tracker's input and result items.
// Depends on rstk_pkg.

interface rstk_in_if;
  logic                          valid;
  logic                          ready;
  logic [rstk_pkg::CMD_W-1:0]    cmd;
  logic [rstk_pkg::SLOT_W-1:0]   slot;
  logic [rstk_pkg::ID_W-1:0]     msg_id;
  logic [rstk_pkg::TIME_W-1:0]   now;

  modport source (output valid, cmd, slot, msg_id, now, input ready);
  modport sink   (input valid, cmd, slot, msg_id, now, output ready);
endinterface

interface rstk_out_if;
  logic                          valid;
  logic                          ready;
  logic [rstk_pkg::KIND_W-1:0]   kind;
  logic [rstk_pkg::SLOT_W-1:0]   out_slot;
  logic [rstk_pkg::ID_W-1:0]     out_id;
  logic                          last;

  modport source (output valid, kind, out_slot, out_id, last, input ready);
  modport sink   (input valid, kind, out_slot, out_id, last, output ready);
endinterface

// ===== design/retransmit_slot_tracker_core.sv =====
// Top level of the retransmit slot tracker: timeout register, sequencer, slot memory.
// Depends on rstk_pkg, rstk_if, rstk_ram, rstk_seq.
//
// Usage: items enter on in_chan (valid/ready) with cmd, slot, msg_id and now;
// results leave on out_chan (valid/ready) with kind, out_slot, out_id and last,
// where last marks the final result of an item. cfg_we/cfg_wdata write the
// 16-bit timeout, which resets to 2.
// Send and ack: the accept cycle captures the item and, for an ack, reads the
// slot memory; once the result register is free, ST_SEND or ST_ACK updates the
// busy flag, for a send writes the slot memory, and loads the result register.
// A tick walks the table at one slot per cycle, paced by the memory read port,
// while the receiver keeps up, and then emits the done marker.
// An unknown command is consumed and gives no result.
// A new item is taken in the cycle after the last result is loaded, while that
// result may still wait in the output register.
// When the receiver stalls, the result register holds and the walk pauses on
// the slot that needs to emit; nothing is dropped.
// Reset clears the busy flags (every slot free), the output register and the
// sequencer; the memory needs no clearing pass and the block is ready at once.

module retransmit_slot_tracker_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rstk_pkg::TMO_W-1:0]  cfg_wdata,
  rstk_in_if.sink                     in_chan,
  rstk_out_if.source                  out_chan
);

  logic [rstk_pkg::TMO_W-1:0] timeout_r;
  rstk_pkg::ram_req_t         ram_req;
  rstk_pkg::entry_t           ram_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= rstk_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  rstk_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .timeout  (timeout_r),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .ram_req  (ram_req),
    .ram_rd   (ram_rd)
  );

  rstk_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready &&
    (in_chan.cmd == rstk_pkg::CMD_SEND || in_chan.cmd == rstk_pkg::CMD_ACK ||
     in_chan.cmd == rstk_pkg::CMD_TICK) |=> !in_chan.ready)
    else $error("item accepted while previous item still in progress");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.last == (out_chan.kind != rstk_pkg::KIND_RETX)))
    else $error("last flag does not match result kind");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid && in_chan.ready)
    else $error("result pending or not ready after reset");

endmodule

// ===== design/rstk_ram.sv =====
// Slot table memory: stamp and id per slot, one write and one registered read port.
// Depends on rstk_pkg.

module rstk_ram (
  input  logic               clk,
  input  rstk_pkg::ram_req_t req,
  output rstk_pkg::entry_t   rd_data
);

  rstk_pkg::entry_t mem [rstk_pkg::NUM_SLOTS];
  rstk_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/rstk_seq.sv =====
// Sequencer: busy flags, item capture, read-modify-write of the slot table,
// timeout scan and the result register. Depends on rstk_pkg, rstk_if.

module rstk_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rstk_pkg::TMO_W-1:0]  timeout,
  rstk_in_if.sink                     in_chan,
  rstk_out_if.source                  out_chan,
  output rstk_pkg::ram_req_t          ram_req,
  input  rstk_pkg::entry_t            ram_rd
);

  localparam int IDX_W = rstk_pkg::IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(rstk_pkg::NUM_SLOTS - 1);

  rstk_pkg::state_t state_r, state_nxt;

  logic [rstk_pkg::NUM_SLOTS-1:0] busy_r;
  logic                           busy_we;
  logic [IDX_W-1:0]               busy_idx;
  logic                           busy_val;

  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [rstk_pkg::SLOT_W-1:0] slot_r;
  logic [rstk_pkg::ID_W-1:0]   id_r;
  logic [rstk_pkg::TIME_W-1:0] now_r;

  logic                          out_valid_r;
  logic [rstk_pkg::KIND_W-1:0]   kind_r;
  logic [rstk_pkg::SLOT_W-1:0]   oslot_r;
  logic [rstk_pkg::ID_W-1:0]     oid_r;
  logic                          last_r;

  logic                          emit;
  logic [rstk_pkg::KIND_W-1:0]   e_kind;
  logic [rstk_pkg::SLOT_W-1:0]   e_slot;
  logic [rstk_pkg::ID_W-1:0]     e_id;
  logic                          e_last;

  logic                        accept;
  logic                        out_free;
  logic [IDX_W-1:0]            free_idx;
  logic                        any_free;
  logic [IDX_W-1:0]            ack_idx;
  logic                        ack_hit;
  logic [rstk_pkg::TIME_W-1:0] age;
  logic                        due;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign ack_idx  = IDX_W'(slot_r);
  assign ack_hit  = (int'(slot_r) < rstk_pkg::NUM_SLOTS) && busy_r[ack_idx] &&
                    (ram_rd.ident == id_r);
  assign age      = now_r - ram_rd.stamp;
  assign due      = busy_r[idx_r] && (age >= rstk_pkg::TIME_W'(timeout));

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = rstk_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rstk_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_chan.ready  = (state_r == rstk_pkg::ST_IDLE);
    ram_req        = '0;
    idx_nxt        = idx_r;
    busy_we        = 1'b0;
    busy_idx       = '0;
    busy_val       = 1'b0;
    emit           = 1'b0;
    e_kind         = rstk_pkg::KIND_DONE;
    e_slot         = '0;
    e_id           = '0;
    e_last         = 1'b1;
    case (state_r)
      rstk_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          case (in_chan.cmd)
            rstk_pkg::CMD_SEND: begin
              state_nxt = rstk_pkg::ST_SEND;
            end
            rstk_pkg::CMD_ACK: begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = IDX_W'(in_chan.slot);
              state_nxt       = rstk_pkg::ST_ACK;
            end
            rstk_pkg::CMD_TICK: begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = '0;
              idx_nxt         = '0;
              state_nxt       = rstk_pkg::ST_SCAN;
            end
            default: begin
              state_nxt = rstk_pkg::ST_IDLE;
            end
          endcase
        end
      end
      rstk_pkg::ST_SEND: begin
        if (out_free) begin
          emit = 1'b1;
          if (any_free) begin
            ram_req.wr_en         = 1'b1;
            ram_req.wr_addr       = free_idx;
            ram_req.wr_data.stamp = now_r;
            ram_req.wr_data.ident = id_r;
            busy_we               = 1'b1;
            busy_idx              = free_idx;
            busy_val              = 1'b1;
            e_kind                = rstk_pkg::KIND_SENT;
            e_slot                = rstk_pkg::SLOT_W'(free_idx);
            e_id                  = id_r;
          end else begin
            e_kind = rstk_pkg::KIND_FULL;
          end
          state_nxt = rstk_pkg::ST_IDLE;
        end
      end
      rstk_pkg::ST_ACK: begin
        if (out_free) begin
          emit   = 1'b1;
          e_slot = slot_r;
          if (ack_hit) begin
            busy_we  = 1'b1;
            busy_idx = ack_idx;
            busy_val = 1'b0;
            e_kind   = rstk_pkg::KIND_ACK_OK;
            e_id     = id_r;
          end else begin
            e_kind = rstk_pkg::KIND_ACK_IGN;
          end
          state_nxt = rstk_pkg::ST_IDLE;
        end
      end
      rstk_pkg::ST_SCAN: begin
        if (!due || out_free) begin
          if (due) begin
            ram_req.wr_en         = 1'b1;
            ram_req.wr_addr       = idx_r;
            ram_req.wr_data.stamp = now_r;
            ram_req.wr_data.ident = id_r;
            emit                  = 1'b1;
            e_kind                = rstk_pkg::KIND_RETX;
            e_slot                = rstk_pkg::SLOT_W'(idx_r);
            e_id                  = id_r;
            e_last                = 1'b0;
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = rstk_pkg::ST_DONE;
          end else begin
            idx_nxt         = idx_r + 1'b1;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = idx_r + 1'b1;
          end
        end
      end
      rstk_pkg::ST_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = rstk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rstk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (busy_we) begin
        busy_r[busy_idx] <= busy_val;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (accept) begin
      slot_r <= in_chan.slot;
      id_r   <= in_chan.msg_id;
      now_r  <= in_chan.now;
    end
    if (emit) begin
      kind_r  <= e_kind;
      oslot_r <= e_slot;
      oid_r   <= e_id;
      last_r  <= e_last;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.kind     = kind_r;
  assign out_chan.out_slot = oslot_r;
  assign out_chan.out_id   = oid_r;
  assign out_chan.last     = last_r;

endmodule
